// ===== sv/mhpq_pkg.sv =====
// Package for the min-heap priority queue: entry and word types, opcodes,
// status codes and default sizes. No dependencies.
package mhpq_pkg;

  localparam int MHPQ_CAPACITY = 256;
  localparam int KEY_W         = 31;
  localparam int ITEM_W        = 9;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 9;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
  } entry_t;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item_id;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    out_key;
    logic [ITEM_W-1:0]   out_item;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

endpackage

// ===== sv/min_heap_priority_queue.sv =====
// Top level of the binary min-heap priority queue with its entry memory.
// Depends on mhpq_pkg.
//
//  channel | ports                      | handshake
//  input   | start, busy, in_word       | taken when start is high and busy is low
//  output  | out_valid, out_word        | one-cycle strobe, cannot be held off
//
// Rejected operations (extract when empty, insert when full) answer in the
// cycle after they are taken. A sift handles each heap level as a memory read,
// then a compare and write.
// The heap memory needs no clearing; only entries in slots below the count are used.
// After reset the count is zero and the block is idle.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = MHPQ_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + COUNT_W;
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_EX_LD  = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;

  entry_t mem [CAPACITY];

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  entry_t        mov_r, mov_nxt;
  entry_t        res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  entry_t        rd_a_r, rd_b_r;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [AW-1:0] parent;
  logic [IW-1:0] lc_idx, rc_idx, cnt_idx;
  logic          lc_ok, rc_ok, take_l, take_r;
  logic [KEY_W-1:0] best_key;
  logic [XW-1:0] cnt_ext;

  assign parent   = (pos_r - AW'(1)) >> 1;
  assign lc_idx   = {1'b0, pos_r, 1'b1};
  assign rc_idx   = lc_idx + IW'(1);
  assign cnt_idx  = IW'(cnt_r);
  assign lc_ok    = lc_idx < cnt_idx;
  assign rc_ok    = rc_idx < cnt_idx;
  assign take_l   = lc_ok && (rd_a_r.key < mov_r.key);
  assign best_key = take_l ? rd_a_r.key : mov_r.key;
  assign take_r   = rc_ok && (rd_b_r.key < best_key);
  assign cnt_ext  = XW'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    mov_nxt       = mov_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = mov_r;
    out_word_nxt.count = cnt_ext[COUNT_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_word_nxt.out_key  = '0;
          out_word_nxt.out_item = '0;
          out_word_nxt.status   = STATUS_OK;
          if (in_word.op == OP_INSERT) begin
            if (cnt_r == CW'(CAPACITY)) begin
              out_word_nxt.status = STATUS_FULL;
              out_valid_nxt       = 1'b1;
            end else begin
              mov_nxt   = '{key: in_word.key, item: in_word.item_id};
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              out_word_nxt.status = STATUS_EMPTY;
              out_valid_nxt       = 1'b1;
            end else begin
              rd_addr_a = '0;
              rd_addr_b = AW'(cnt_r - CW'(1));
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_EX_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_addr_a = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a_r.key > mov_r.key) begin
          wr_data   = rd_a_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EX_LD: begin
        res_nxt   = rd_a_r;
        mov_nxt   = rd_b_r;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        rd_addr_a = lc_idx[AW-1:0];
        rd_addr_b = rc_idx[AW-1:0];
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data   = rd_b_r;
          pos_nxt   = rc_idx[AW-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          wr_data   = rd_a_r;
          pos_nxt   = lc_idx[AW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          out_word_nxt.out_key  = res_r.key;
          out_word_nxt.out_item = res_r.item;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    mov_r      <= mov_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/mhpq_checker.sv =====
// Port-level checker for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("Accepted word neither answered nor in progress.");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while still busy.");

  a_result_caused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("Result without an accepted word.");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STATUS_EMPTY) |->
      (out_word.count == '0 && out_word.out_key == '0 && out_word.out_item == '0))
    else $error("Empty status with nonzero fields.");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STATUS_FULL) |->
      (out_word.out_key == '0 && out_word.out_item == '0))
    else $error("Full status with nonzero entry fields.");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
